// ===== rtl/core/itbd_pkg.sv =====
// Shared types, constants and helpers for the integer to base digits converter.
package itbd_pkg;

    localparam int DIGIT_W     = 6;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 8;
    localparam int IN_VALUE_W  = 32;
    localparam int IN_TDATA_W  = 40;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [DIGIT_W-1:0] DIGIT_LIMIT = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A      = 8'h41;
    localparam logic [CHAR_W-1:0]  CHAR_ERROR  = 8'h00;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_LOAD,
        S_SEND
    } conv_state_t;

    // digit value to ASCII: 0-9 then A-Z
    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_LIMIT)
            return CHAR_ZERO + d_ext;
        else
            return CHAR_A + d_ext - {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_LIMIT};
    endfunction

endpackage

// ===== rtl/core/itbd_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, small divisor.
module itbd_divider #(
    parameter int WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [WIDTH-1:0]              dividend,
    input  logic [itbd_pkg::RADIX_W-1:0]  divisor,
    output logic                          done,
    output logic [WIDTH-1:0]              quotient,
    output logic [itbd_pkg::DIGIT_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(WIDTH);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [WIDTH-1:0]              quo_reg, quo_next;
    logic [itbd_pkg::DIGIT_W-1:0]  rem_reg, rem_next;

    logic [itbd_pkg::DIGIT_W:0]    shifted;
    logic [itbd_pkg::DIGIT_W:0]    diff;
    logic                          fits;

    // shift in the next dividend bit and try the subtraction
    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign fits    = (shifted >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[WIDTH-2:0], fits};
            rem_next = fits ? diff[itbd_pkg::DIGIT_W-1:0]
                            : shifted[itbd_pkg::DIGIT_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WIDTH-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/itbd_digit_mem.sv =====
// Digit store: one write port, one registered read port.
module itbd_digit_mem #(
    parameter int DEPTH = 32
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [itbd_pkg::DIGIT_W-1:0]  wr_data,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [itbd_pkg::DIGIT_W-1:0]  rd_data
);

    logic [itbd_pkg::DIGIT_W-1:0] mem [DEPTH];
    logic [itbd_pkg::DIGIT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/integer_to_base_digits_top.sv =====
// Top level of the integer to base digits converter: sequencer, digit store, output word.
//
// Converts an unsigned value to ASCII digits in a base from 2 to 36 and streams
// them out most significant first ('0'-'9' then 'A'-'Z'), one character per
// output word, with tlast on the final one. A zero value gives a single '0'.
// A base outside 2..36 gives one word with character 0, tlast and tuser (error)
// set. Only the low VALUE_BITS bits of the value are used (all 32 above that).
// Timing: one conversion at a time; s_axis_tready is high only while idle.
// Each digit costs one pass of the shared bit-serial divider, and each
// character is then read from the digit store and loaded into the output
// word, plus any wait on m_axis_tready. An error or a zero value skips the
// divider and goes straight to the output word. Digits beyond MAX_DIGITS
// are dropped at the most significant end.
module integer_to_base_digits_top #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [itbd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [31:0] value, [37:32] radix, [39:38] unused
    // output words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [itbd_pkg::CHAR_W-1:0]         m_axis_tdata,  // [7:0] character
    output logic                                m_axis_tlast,  // last character of the conversion
    output logic                                m_axis_tuser   // [0] error: radix out of range
);

    // working width of the value: the field is 32 bits wide
    localparam int QW = (VALUE_BITS < itbd_pkg::IN_VALUE_W) ? VALUE_BITS
                                                             : itbd_pkg::IN_VALUE_W;
    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    itbd_pkg::conv_state_t state_reg, state_next;

    logic [QW-1:0]                  quo_reg, quo_next;
    logic [itbd_pkg::RADIX_W-1:0]   radix_reg, radix_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [AW-1:0]                  idx_reg, idx_next;
    logic                           start_reg, start_next;
    logic [itbd_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic                           last_reg, last_next;
    logic                           err_reg, err_next;

    logic                           in_fire;
    logic                           out_fire;
    logic [QW-1:0]                  in_value;
    logic [itbd_pkg::RADIX_W-1:0]   in_radix;
    logic                           radix_ok;
    logic                           div_done;
    logic [QW-1:0]                  div_quo;
    logic [itbd_pkg::DIGIT_W-1:0]   div_rem;
    logic [itbd_pkg::DIGIT_W-1:0]   rd_data;
    logic                           wr_en;
    logic                           conv_end;

    assign in_value = s_axis_tdata[QW-1:0];
    assign in_radix = s_axis_tdata[itbd_pkg::IN_VALUE_W +: itbd_pkg::RADIX_W];

    always_comb
    begin
        radix_ok = in_radix inside {[itbd_pkg::RADIX_MIN:itbd_pkg::RADIX_MAX]};
    end

    assign s_axis_tready = (state_reg == itbd_pkg::S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == itbd_pkg::S_SEND);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = char_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = err_reg;

    // a digit lands each time the divider finishes; stop on a zero quotient
    // or when the store is full
    assign wr_en    = (state_reg == itbd_pkg::S_DIV) && div_done;
    assign conv_end = (div_quo == '0) || ((count_reg + 1'b1) == CW'(MAX_DIGITS));

    itbd_divider #(
        .WIDTH (QW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .dividend  (quo_reg),
        .divisor   (radix_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    itbd_digit_mem #(
        .DEPTH (MAX_DIGITS)
    ) u_digit_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (div_rem),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            itbd_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (!radix_ok || (in_value == '0))
                        state_next = itbd_pkg::S_SEND;
                    else
                        state_next = itbd_pkg::S_DIV;
                end
            end
            itbd_pkg::S_DIV:
            begin
                if (div_done && conv_end)
                    state_next = itbd_pkg::S_READ;
            end
            itbd_pkg::S_READ:
                state_next = itbd_pkg::S_LOAD;
            itbd_pkg::S_LOAD:
                state_next = itbd_pkg::S_SEND;
            itbd_pkg::S_SEND:
            begin
                if (out_fire)
                    state_next = last_reg ? itbd_pkg::S_IDLE : itbd_pkg::S_READ;
            end
            default:
                state_next = itbd_pkg::S_IDLE;
        endcase
    end

    // datapath and output word
    always_comb
    begin
        quo_next   = quo_reg;
        radix_next = radix_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        start_next = 1'b0;
        char_next  = char_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        case (state_reg)
            itbd_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    quo_next   = in_value;
                    radix_next = in_radix;
                    count_next = '0;
                    last_next  = 1'b1;
                    if (!radix_ok)
                    begin
                        char_next = itbd_pkg::CHAR_ERROR;
                        err_next  = 1'b1;
                    end
                    else if (in_value == '0)
                    begin
                        char_next = itbd_pkg::CHAR_ZERO;
                        err_next  = 1'b0;
                    end
                    else
                    begin
                        start_next = 1'b1;
                    end
                end
            end
            itbd_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    quo_next   = div_quo;
                    count_next = count_reg + 1'b1;
                    idx_next   = count_reg[AW-1:0];
                    start_next = !conv_end;
                end
            end
            itbd_pkg::S_LOAD:
            begin
                char_next = itbd_pkg::ascii_of(rd_data);
                last_next = (idx_reg == '0);
                err_next  = 1'b0;
            end
            itbd_pkg::S_SEND:
            begin
                if (out_fire && !last_reg)
                    idx_next = idx_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itbd_pkg::S_IDLE;
            start_reg <= 1'b0;
            count_reg <= '0;
            quo_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            count_reg <= count_next;
            quo_reg   <= quo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
        idx_reg   <= idx_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        err_reg   <= err_next;
    end

endmodule
